// ----- hdl/esd_pkg.sv -----
// Package for the escape sequence decoder.
// Holds the request and result types, decode modes, character codes and hex helpers.
// No dependencies.
package esd_pkg;

  // One input request: a character, or the end-of-string marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_escape;
    logic       string_done;
    logic       run_last;
  } out_item_t;

  // Decode modes.
  typedef enum logic [2:0] {
    M_NORMAL    = 3'd0,
    M_ESC       = 3'd1,
    M_HEX_START = 3'd2,
    M_HEX_NEXT  = 3'd3,
    M_HEX_LOW   = 3'd4
  } mode_t;

  // Decoder output toward the result queue.
  typedef struct packed {
    logic      push;
    logic [1:0] n_res;
    out_item_t res0;
    out_item_t res1;
  } dec_out_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  // Value of a hex digit character; zero for anything else.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {["0":"9"]}) begin
      v = c - "0";
    end else if (c inside {["a":"f"]}) begin
      v = c - "a" + 8'd10;
    end else if (c inside {["A":"F"]}) begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hdl/esd_decode.sv -----
// Escape decode stage: mode and held-digit state plus the per-request decode logic.
// Uses esd_pkg for types, modes and hex helpers.
module esd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  esd_pkg::in_item_t item,
  output esd_pkg::dec_out_t dec
);

  esd_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     held_r, held_nxt;

  // Builds one result with run_last clear.
  function automatic esd_pkg::out_item_t mk(input logic [7:0] b, input logic has,
                                            input logic bad, input logic done);
    esd_pkg::out_item_t r;
    r.out_byte    = has ? b : 8'd0;
    r.has_byte    = has;
    r.bad_escape  = bad;
    r.string_done = done;
    r.run_last    = 1'b0;
    return r;
  endfunction

  logic [7:0]         c;
  logic [7:0]         lc;
  esd_pkg::out_item_t plain_res;
  logic               plain_emits;
  esd_pkg::mode_t     plain_mode;
  esd_pkg::out_item_t r0, r1;
  logic [1:0]         n;

  // Handling of the character as plain text, shared by several modes.
  always_comb begin
    c           = item.ch;
    lc          = (c inside {["A":"Z"]}) ? c + esd_pkg::CASE_GAP : c;
    plain_res   = mk(c, 1'b1, 1'b0, 1'b0);
    plain_emits = (c != esd_pkg::CH_BSLASH);
    plain_mode  = plain_emits ? esd_pkg::M_NORMAL : esd_pkg::M_ESC;
  end

  // Next state and results for one request.
  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;
    if (item.at_end) begin
      n        = 2'd1;
      mode_nxt = esd_pkg::M_NORMAL;
      held_nxt = 8'd0;
      case (mode_r)
        esd_pkg::M_ESC:       r0 = mk(esd_pkg::CH_QMARK, 1'b1, 1'b1, 1'b1);
        esd_pkg::M_HEX_START: r0 = mk(8'd0, 1'b0, 1'b1, 1'b1);
        esd_pkg::M_HEX_LOW:   r0 = mk(held_r, 1'b1, 1'b0, 1'b1);
        default:              r0 = mk(8'd0, 1'b0, 1'b0, 1'b1);
      endcase
    end else begin
      case (mode_r)
        esd_pkg::M_ESC: begin
          mode_nxt = esd_pkg::M_NORMAL;
          n        = 2'd1;
          case (lc)
            "a":     r0 = mk(8'd7, 1'b1, 1'b0, 1'b0);
            "b":     r0 = mk(8'd8, 1'b1, 1'b0, 1'b0);
            "f":     r0 = mk(8'd12, 1'b1, 1'b0, 1'b0);
            "v":     r0 = mk(8'd11, 1'b1, 1'b0, 1'b0);
            "r":     r0 = mk(8'd13, 1'b1, 1'b0, 1'b0);
            "n":     r0 = mk(8'd10, 1'b1, 1'b0, 1'b0);
            "t":     r0 = mk(8'd9, 1'b1, 1'b0, 1'b0);
            esd_pkg::CH_QUOTE, esd_pkg::CH_DQUOTE, esd_pkg::CH_BSLASH:
                     r0 = mk(c, 1'b1, 1'b0, 1'b0);
            "x": begin
              mode_nxt = esd_pkg::M_HEX_START;
              n        = 2'd0;
            end
            default: r0 = mk(esd_pkg::CH_QMARK, 1'b1, 1'b1, 1'b0);
          endcase
        end
        esd_pkg::M_HEX_START, esd_pkg::M_HEX_NEXT: begin
          if (esd_pkg::is_hex(c)) begin
            held_nxt = c;
            mode_nxt = esd_pkg::M_HEX_LOW;
          end else begin
            r0       = plain_res;
            n        = {1'b0, plain_emits};
            mode_nxt = plain_mode;
          end
        end
        esd_pkg::M_HEX_LOW: begin
          held_nxt = 8'd0;
          if (esd_pkg::is_hex(c)) begin
            r0       = mk({esd_pkg::hex_val(held_r), esd_pkg::hex_val(c)}, 1'b1, 1'b0, 1'b0);
            n        = 2'd1;
            mode_nxt = esd_pkg::M_HEX_NEXT;
          end else begin
            // A lone digit goes out literally, then the character is plain text.
            r0       = mk(held_r, 1'b1, 1'b0, 1'b0);
            r1       = plain_res;
            n        = plain_emits ? 2'd2 : 2'd1;
            mode_nxt = plain_mode;
          end
        end
        default: begin
          r0       = plain_res;
          n        = {1'b0, plain_emits};
          mode_nxt = plain_mode;
        end
      endcase
    end
    // Mark the last result of this request.
    if (n == 2'd1) begin
      r0.run_last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end
    dec.push  = item_vld;
    dec.n_res = n;
    dec.res0  = r0;
    dec.res1  = r1;
  end

  // Decode state advances once per consumed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esd_pkg::M_NORMAL;
      held_r <= 8'd0;
    end else if (item_vld) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ----- hdl/esd_resq.sv -----
// Result queue: four entries, takes up to two results per cycle, gives one per cycle while the receiver does not stall.
// Uses esd_pkg for the result and decoder types.
module esd_resq (
  input  logic               clk,
  input  logic               rst_n,
  input  esd_pkg::dec_out_t  dec,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output esd_pkg::out_item_t out_data
);

  esd_pkg::out_item_t q_r [4];
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] push_n;
  logic       pop;

  // Pointer and fill arithmetic.
  always_comb begin
    push_n     = dec.push ? dec.n_res : 2'd0;
    pop        = (count_r != 3'd0) && !out_stall;
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};
  end

  // Room for a full two-result request.
  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= dec.res1;
    end
  end

endmodule

// ----- hdl/escape_sequence_decoder.sv -----
// Top level of the escape sequence decoder.
// Instantiates esd_decode and esd_resq; uses esd_pkg for the channel types.
//
// Usage: characters of a string arrive as requests on the in_ channel, closed
// by a request with at_end set. Results leave on the out_ channel, each with
// run_last marking the last result a request caused. A request may cause zero,
// one or two results; the end request always causes exactly one.
// Path: a request held in the input register is decoded once the queue has
// room; its results are written into the result queue for the out_ channel.
// Throughput: one request per cycle while each gives at most one result and
// the receiver does not stall; a request that gives two results is drained
// one result at a time through the single read port of the four-entry result
// queue.
// Reset clears the decode mode, the held digit and the queue; nothing is
// pending afterwards. When the receiver stalls, the result on out_data holds
// and the queue fills; once fewer than two free entries remain the input
// register holds its request and in_stall rises.
module escape_sequence_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  esd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output esd_pkg::out_item_t out_data
);

  logic              in_valid_r;
  esd_pkg::in_item_t in_data_r;
  logic              room;
  logic              consume;
  esd_pkg::dec_out_t dec;

  // The input register is drained whenever the queue can take two results.
  assign consume  = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  esd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (consume),
    .item     (in_data_r),
    .dec      (dec)
  );

  esd_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/esd_checker.sv -----
// Port-level checker for the escape sequence decoder, bound to the top level.
// Uses esd_pkg for the channel types.
module esd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input esd_pkg::out_item_t out_data
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result without a byte only answers an end request.
  a_nobyte_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.string_done && out_data.out_byte == 8'd0)
    else $error("empty result outside string end");

  // The end result is always the last of its request.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |-> out_data.run_last)
    else $error("end result not marked last");

  // The input side only stalls while a request is held.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(in_valid) || $past(in_stall))
    else $error("stall with no held request");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);
